@@ sv/cdd_pkg.sv @@
// shared types and constants for the clock drift discipline block
package cdd_pkg;

    localparam int unsigned UNITS_PER_SECOND_DEF = 1000000000;
    localparam logic [31:0] NOMINAL_RESET = 32'd4000000;

    localparam int TIME_W   = 62;
    localparam int WIDE_W   = 64;
    localparam int WORD_W   = 32;
    localparam int STEP_W   = 30;
    localparam int SMAG_W   = 29;
    localparam int CFG_IDX_W = 2;

    // reciprocal of ten for 32-bit operands: x / 10 == (x * RECIP10) >> RECIP10_SHIFT
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP10_SHIFT = 35;

    localparam logic [CFG_IDX_W-1:0] REG_BOOT_SECONDS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL_TICK = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        DIV_SLEW,
        DIV_GAP,
        DIV_RATE
    } div_sel_t;

    typedef struct packed {
        logic     load_in;
        logic     mul;
        logic     calc_drift;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_q;
        logic     cap_tgap;
        logic     cap_dpt;
        logic     finish;
    } cdd_cmd_t;

    typedef struct packed {
        logic drift_zero;
        logic smag_zero;
        logic nudge_ok;
        logic tgap_zero;
        logic div_done;
    } cdd_status_t;

endpackage

@@ sv/cdd_div.sv @@
// 64-bit unsigned restoring divider, one quotient bit per cycle
module cdd_div
    import cdd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [WIDE_W-1:0] dividend,
    input  logic [WIDE_W-1:0] divisor,
    output logic              done,
    output logic [WIDE_W-1:0] quotient
);

    localparam int CNT_W = $clog2(WIDE_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [WIDE_W-1:0] rem_reg;
    logic [WIDE_W-1:0] quo_reg;
    logic [WIDE_W-1:0] dsr_reg;

    logic [WIDE_W:0]   shifted;
    logic [WIDE_W:0]   diff;
    logic              fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[WIDE_W-1]};
        diff    = shifted - {1'b0, dsr_reg};
        fits    = (shifted >= {1'b0, dsr_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[WIDE_W-1:0] : shifted[WIDE_W-1:0];
            quo_reg <= {quo_reg[WIDE_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ sv/cdd_datapath.sv @@
// datapath: drift arithmetic, slew and tick state, counters and result register
module cdd_datapath
    import cdd_pkg::*;
#(
    parameter int unsigned UNITS_PER_SECOND = UNITS_PER_SECOND_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cdd_cmd_t             cmd,
    output cdd_status_t          status,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    input  logic [TIME_W-1:0]    edge_time,
    input  logic [WORD_W-1:0]    rtc_seconds,
    input  logic [TIME_W-1:0]    now_time,
    output logic signed [WIDE_W-1:0] drift,
    output logic signed [STEP_W-1:0] slew_step,
    output logic [WORD_W-1:0]    slew_ticks,
    output logic [WORD_W-1:0]    tick_length,
    output logic                 first_resync,
    output logic                 multi_second,
    output logic [WORD_W-1:0]    resync_total,
    output logic [WORD_W-1:0]    multi_second_total
);

    localparam int SCALE_W = $clog2(UNITS_PER_SECOND + 1);
    localparam int PROD_W  = WORD_W + 1 + SCALE_W + 1;
    localparam logic [SCALE_W-1:0] SCALE    = SCALE_W'(UNITS_PER_SECOND);
    localparam logic [WIDE_W-1:0]  SCALE_WD = WIDE_W'(UNITS_PER_SECOND);

    // architectural state
    logic [WORD_W-1:0]  boot_reg;
    logic [WORD_W-1:0]  tick_reg;
    logic [TIME_W-1:0]  last_time_reg;
    logic               last_pos_reg;
    logic               seen_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [WORD_W-1:0]  ticks_reg;
    logic [WORD_W-1:0]  resync_cnt_reg;
    logic [WORD_W-1:0]  multi_cnt_reg;
    logic               nudge_hit_reg;

    // per-item working registers
    logic [TIME_W-1:0]  edge_reg;
    logic [WORD_W-1:0]  rtc_reg;
    logic [TIME_W-1:0]  now_reg;
    logic [WIDE_W-1:0]  prod_reg;
    logic [SMAG_W-1:0]  smag_reg;
    logic [WIDE_W-1:0]  drift_reg;
    logic [WIDE_W-1:0]  q_reg;
    logic [WIDE_W-1:0]  tgap_reg;
    logic [WIDE_W-1:0]  dpt_reg;

    // result register
    logic [WIDE_W-1:0]  out_drift_reg;
    logic [STEP_W-1:0]  out_step_reg;
    logic [WORD_W-1:0]  out_ticks_reg;
    logic [WORD_W-1:0]  out_tick_reg;
    logic               out_first_reg;
    logic               out_multi_reg;
    logic [WORD_W-1:0]  out_resync_reg;
    logic [WORD_W-1:0]  out_mcnt_reg;

    logic signed [WORD_W:0]  secs;
    logic signed [SCALE_W:0] scale_s;
    logic signed [PROD_W-1:0] prod_full;
    logic [2*WORD_W-1:0]     recip_prod;
    logic [WIDE_W-1:0]       drift_next;
    logic                    neg;
    logic                    drift_zero;
    logic [WIDE_W-1:0]       mag;
    logic [WIDE_W-1:0]       gap;
    logic [WIDE_W-1:0]       div_dividend;
    logic [WIDE_W-1:0]       div_divisor;
    logic                    div_done;
    logic [WIDE_W-1:0]       div_quotient;
    logic [WORD_W-1:0]       adj_whole;
    logic [3:0]              adj_frac;
    logic [WORD_W-1:0]       adj32;
    logic [STEP_W-1:0]       step_next;
    logic [WORD_W-1:0]       ticks_next;
    logic [WORD_W-1:0]       tick_next;
    logic                    multi;
    logic [WORD_W-1:0]       resync_next;
    logic [WORD_W-1:0]       mcnt_next;

    always_comb
    begin
        secs       = $signed({1'b0, rtc_reg}) - $signed({1'b0, boot_reg});
        scale_s    = $signed({1'b0, SCALE});
        prod_full  = secs * scale_s;
        recip_prod = tick_reg * RECIP10;
        drift_next = {2'b00, edge_reg} - prod_reg;
        neg        = drift_reg[WIDE_W-1];
        drift_zero = (drift_reg == '0);
        mag        = neg ? (WIDE_W'(0) - drift_reg) : drift_reg;
        gap        = {2'b00, now_reg} - {2'b00, last_time_reg};
    end

    always_comb
    begin
        unique case (cmd.div_sel)
            DIV_SLEW:
            begin
                div_dividend = mag;
                div_divisor  = WIDE_W'(smag_reg);
            end
            DIV_GAP:
            begin
                div_dividend = gap;
                div_divisor  = WIDE_W'(tick_reg);
            end
            DIV_RATE:
            begin
                div_dividend = mag;
                div_divisor  = tgap_reg;
            end
            default:
            begin
                div_dividend = mag;
                div_divisor  = tgap_reg;
            end
        endcase
    end

    cdd_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // three quarters of the drift per tick, truncated, low word only
    always_comb
    begin
        adj_whole = dpt_reg[WORD_W+1:2];
        adj_frac  = {2'b00, dpt_reg[1:0]} + {1'b0, dpt_reg[1:0], 1'b0};
        adj32     = adj_whole + {adj_whole[WORD_W-2:0], 1'b0} + WORD_W'(adj_frac[3:2]);
    end

    always_comb
    begin
        step_next  = step_reg;
        ticks_next = ticks_reg;
        if (!drift_zero)
        begin
            if (smag_reg == '0)
            begin
                step_next  = '0;
                ticks_next = '0;
            end
            else
            begin
                ticks_next = (|q_reg[WIDE_W-1:WORD_W]) ? '1 : q_reg[WORD_W-1:0];
                step_next  = neg ? (STEP_W'(0) - STEP_W'(smag_reg)) : STEP_W'(smag_reg);
            end
        end
        tick_next = tick_reg;
        if (nudge_hit_reg)
        begin
            tick_next = neg ? (tick_reg + adj32) : (tick_reg - adj32);
        end
        multi       = (mag > SCALE_WD);
        resync_next = resync_cnt_reg + 1'b1;
        mcnt_next   = multi ? (multi_cnt_reg + 1'b1) : multi_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            boot_reg       <= '0;
            tick_reg       <= NOMINAL_RESET;
            last_time_reg  <= '0;
            last_pos_reg   <= 1'b0;
            seen_reg       <= 1'b0;
            step_reg       <= '0;
            ticks_reg      <= '0;
            resync_cnt_reg <= '0;
            multi_cnt_reg  <= '0;
            nudge_hit_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            tick_reg       <= tick_next;
            last_time_reg  <= now_reg;
            last_pos_reg   <= !neg && !drift_zero;
            seen_reg       <= 1'b1;
            step_reg       <= step_next;
            ticks_reg      <= ticks_next;
            resync_cnt_reg <= resync_next;
            multi_cnt_reg  <= mcnt_next;
        end
        else
        begin
            if (cmd.load_in)
            begin
                nudge_hit_reg <= 1'b0;
            end
            else if (cmd.cap_dpt)
            begin
                nudge_hit_reg <= 1'b1;
            end
            if (cfg_we && (cfg_index == REG_BOOT_SECONDS))
            begin
                boot_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == REG_NOMINAL_TICK))
            begin
                tick_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            edge_reg <= edge_time;
            rtc_reg  <= rtc_seconds;
            now_reg  <= now_time;
        end
        if (cmd.mul)
        begin
            prod_reg <= WIDE_W'(prod_full);
            smag_reg <= recip_prod[RECIP10_SHIFT +: SMAG_W];
        end
        if (cmd.calc_drift)
        begin
            drift_reg <= drift_next;
        end
        if (cmd.cap_q)
        begin
            q_reg <= div_quotient;
        end
        if (cmd.cap_tgap)
        begin
            tgap_reg <= div_quotient;
        end
        if (cmd.cap_dpt)
        begin
            dpt_reg <= div_quotient;
        end
        if (cmd.finish)
        begin
            out_drift_reg  <= drift_reg;
            out_step_reg   <= step_next;
            out_ticks_reg  <= ticks_next;
            out_tick_reg   <= tick_next;
            out_first_reg  <= !seen_reg;
            out_multi_reg  <= multi;
            out_resync_reg <= resync_next;
            out_mcnt_reg   <= mcnt_next;
        end
    end

    always_comb
    begin
        status.drift_zero = drift_zero;
        status.smag_zero  = (smag_reg == '0);
        status.nudge_ok   = seen_reg && ((!neg && !drift_zero) == last_pos_reg)
                            && (tick_reg != '0);
        status.tgap_zero  = (tgap_reg == '0);
        status.div_done   = div_done;
    end

    assign drift              = $signed(out_drift_reg);
    assign slew_step          = $signed(out_step_reg);
    assign slew_ticks         = out_ticks_reg;
    assign tick_length        = out_tick_reg;
    assign first_resync       = out_first_reg;
    assign multi_second       = out_multi_reg;
    assign resync_total       = out_resync_reg;
    assign multi_second_total = out_mcnt_reg;

endmodule

@@ sv/cdd_ctrl.sv @@
// controller: sequences one resync item through the datapath and owns the handshakes
module cdd_ctrl
    import cdd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    output cdd_cmd_t    cmd,
    input  cdd_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_DRIFT,
        S_SLEW,
        S_SLEW_WAIT,
        S_GAP,
        S_GAP_WAIT,
        S_RATE,
        S_RATE_WAIT,
        S_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        cmd        = '0;
        cmd.div_sel = DIV_SLEW;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DRIFT;
            end
            S_DRIFT:
            begin
                cmd.calc_drift = 1'b1;
                state_next     = S_SLEW;
            end
            S_SLEW:
            begin
                cmd.div_sel = DIV_SLEW;
                if (!status.drift_zero && !status.smag_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_SLEW_WAIT;
                end
                else
                begin
                    state_next = S_GAP;
                end
            end
            S_SLEW_WAIT:
            begin
                cmd.cap_q = status.div_done;
                if (status.div_done)
                begin
                    state_next = S_GAP;
                end
            end
            S_GAP:
            begin
                cmd.div_sel = DIV_GAP;
                if (status.nudge_ok)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_GAP_WAIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_GAP_WAIT:
            begin
                cmd.cap_tgap = status.div_done;
                if (status.div_done)
                begin
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                cmd.div_sel = DIV_RATE;
                if (!status.tgap_zero)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_RATE_WAIT;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_RATE_WAIT:
            begin
                cmd.div_sel = DIV_RATE;
                cmd.cap_dpt = status.div_done;
                if (status.div_done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                cmd.finish = out_free;
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // an accepted item keeps the input closed until its result is written
    a_accept_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input open right after an item was accepted");

    // the divider never reports done in the cycle after it was started
    a_div_takes_time: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !status.div_done)
        else $error("divider done one cycle after start");

    // a new result only appears out of the finishing state
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result raised outside the finishing state");

    // a finish never overwrites a result that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten while stalled");

endmodule

@@ sv/clock_drift_discipline.sv @@
// top level of the clock drift discipline block
// Each accepted input item is one resync event: the system time seen at an RTC
// seconds tick, the RTC seconds read just after it, and the current system time.
// The block works out drift = edge_time - (rtc_seconds - boot_seconds) * units per
// second (modulo 2^64), loads a slew of +-tick/10 per tick for |drift|/step ticks
// when the drift is nonzero, and on a later event whose drift sign matches the
// previous one moves the tick length by 3/4 of the drift per elapsed tick. It also
// counts resync events and events whose drift exceeds one second. One item is
// handled at a time; an item needs from none up to three 64-bit divisions
// (drift by step, gap by tick, drift by elapsed ticks), all run in turn on the
// single shared radix-2 divider. The finished result sits in an output register,
// so the next item is taken as soon as the previous result has been written there.
// Writing nominal_tick also reloads the tick length; configuration is always
// ready and is only to be written while the block is idle.
module clock_drift_discipline
    import cdd_pkg::*;
#(
    parameter int unsigned UNITS_PER_SECOND = UNITS_PER_SECOND_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // resync item in
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [TIME_W-1:0]        edge_time,
    input  logic [WORD_W-1:0]        rtc_seconds,
    input  logic [TIME_W-1:0]        now_time,
    // result item out
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WIDE_W-1:0] drift,
    output logic signed [STEP_W-1:0] slew_step,
    output logic [WORD_W-1:0]        slew_ticks,
    output logic [WORD_W-1:0]        tick_length,
    output logic                     first_resync,
    output logic                     multi_second,
    output logic [WORD_W-1:0]        resync_total,
    output logic [WORD_W-1:0]        multi_second_total,
    // register writes
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [WORD_W-1:0]        cfg_data
);

    cdd_cmd_t    cmd;
    cdd_status_t status;
    logic        cfg_we;

    // register writes are always accepted, no back-pressure needed
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    cdd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    cdd_datapath #(
        .UNITS_PER_SECOND (UNITS_PER_SECOND)
    ) u_datapath (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .edge_time          (edge_time),
        .rtc_seconds        (rtc_seconds),
        .now_time           (now_time),
        .drift              (drift),
        .slew_step          (slew_step),
        .slew_ticks         (slew_ticks),
        .tick_length        (tick_length),
        .first_resync       (first_resync),
        .multi_second       (multi_second),
        .resync_total       (resync_total),
        .multi_second_total (multi_second_total)
    );

endmodule

@@ sim/tb_clock_drift_discipline.sv @@
// testbench for clock_drift_discipline: directed and random resync items against a predictor
module tb_clock_drift_discipline;
    timeunit 1ns;
    timeprecision 1ps;

    import cdd_pkg::*;

    localparam logic [63:0]       UNITS      = 64'(UNITS_PER_SECOND_DEF);
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [31:0]       WORD_MAX   = 32'hFFFF_FFFF;
    // longest item is one where all three divisions run
    localparam int                DRAIN_WAIT = 256;
    localparam int                ITEMS_PER_PHASE = 250;

    // one result item as seen on the output ports
    typedef struct packed {
        logic [63:0] drift;
        logic [29:0] slew_step;
        logic [31:0] slew_ticks;
        logic [31:0] tick_length;
        logic        first_resync;
        logic        multi_second;
        logic [31:0] resync_total;
        logic [31:0] multi_second_total;
    } resync_result_t;

    // predicts each resync result and checks what comes out of the block
    class drift_scoreboard;
        logic [31:0]    boot_secs;
        logic [31:0]    nominal;
        logic [31:0]    tick_len;
        logic [63:0]    last_time;
        logic [63:0]    last_drift;
        logic [31:0]    step;
        logic [31:0]    ticks;
        logic [31:0]    resync_cnt;
        logic [31:0]    multi_cnt;
        logic           seen;
        resync_result_t pending_results[$];
        int             mismatches;
        int             checked;
        int             multi_seen;

        function new();
            boot_secs  = '0;
            nominal    = NOMINAL_RESET;
            tick_len   = NOMINAL_RESET;
            last_time  = '0;
            last_drift = '0;
            step       = '0;
            ticks      = '0;
            resync_cnt = '0;
            multi_cnt  = '0;
            seen       = 1'b0;
            mismatches = 0;
            checked    = 0;
            multi_seen = 0;
        endfunction

        function void apply_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
            if (idx == REG_BOOT_SECONDS)
            begin
                boot_secs = val;
            end
            else if (idx == REG_NOMINAL_TICK)
            begin
                nominal  = val;
                tick_len = val;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction

        function void note_resync(logic [TIME_W-1:0] edge_v, logic [31:0] rtc_v,
                                  logic [TIME_W-1:0] now_v);
            logic [63:0]    secs;
            logic [63:0]    dr;
            logic [63:0]    mag;
            logic [63:0]    quot;
            logic [63:0]    gap;
            logic [63:0]    tgap;
            logic [63:0]    dpt;
            logic [63:0]    adj;
            logic [31:0]    smag;
            logic           neg;
            logic           first;
            logic           ahead;
            logic           was_ahead;
            logic           multi;
            resync_result_t r;

            secs      = {32'd0, rtc_v} - {32'd0, boot_secs};
            dr        = {2'b00, edge_v} - secs * UNITS;
            neg       = dr[63];
            mag       = neg ? 64'd0 - dr : dr;
            first     = !seen;
            ahead     = (dr != 0) && !dr[63];
            was_ahead = (last_drift != 0) && !last_drift[63];

            // slew load, zero drift leaves it alone
            if (dr != 0)
            begin
                smag = tick_len / 32'd10;
                if (smag == 0)
                begin
                    step  = '0;
                    ticks = '0;
                end
                else
                begin
                    quot  = mag / {32'd0, smag};
                    ticks = (quot > {32'd0, WORD_MAX}) ? WORD_MAX : quot[31:0];
                    step  = neg ? 32'd0 - smag : smag;
                end
            end

            // tick nudge by 3/4 of drift per elapsed tick
            if (!first && (ahead == was_ahead) && (tick_len != 0))
            begin
                gap  = {2'b00, now_v} - last_time;
                tgap = gap / {32'd0, tick_len};
                if (tgap != 0)
                begin
                    dpt = mag / tgap;
                    adj = (dpt / 4) * 3 + ((dpt % 4) * 3) / 4;
                    tick_len = neg ? tick_len + adj[31:0] : tick_len - adj[31:0];
                end
            end

            last_time  = {2'b00, now_v};
            last_drift = dr;
            seen       = 1'b1;
            resync_cnt = resync_cnt + 1;
            multi      = mag > UNITS;
            if (multi)
            begin
                multi_cnt = multi_cnt + 1;
            end

            r.drift              = dr;
            r.slew_step          = step[29:0];
            r.slew_ticks         = ticks;
            r.tick_length        = tick_len;
            r.first_resync       = first;
            r.multi_second       = multi;
            r.resync_total       = resync_cnt;
            r.multi_second_total = multi_cnt;
            pending_results.push_back(r);
        endfunction

        // one line per mismatch, printing capped so a broken block cannot flood the log
        task report(string what, logic [63:0] got, logic [63:0] want);
            if (mismatches < 60)
            begin
                $display("%0t: %s got %h want %h", $time, what, got, want);
            end
            mismatches++;
        endtask

        task check_result(resync_result_t got);
            resync_result_t want;

            if (pending_results.size() == 0)
            begin
                report("result with nothing pending, drift", got.drift, '0);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (want.multi_second)
            begin
                multi_seen++;
            end
            if (got.drift != want.drift)
                report("drift", got.drift, want.drift);
            if (got.slew_step != want.slew_step)
                report("slew_step", 64'(got.slew_step), 64'(want.slew_step));
            if (got.slew_ticks != want.slew_ticks)
                report("slew_ticks", 64'(got.slew_ticks), 64'(want.slew_ticks));
            if (got.tick_length != want.tick_length)
                report("tick_length", 64'(got.tick_length), 64'(want.tick_length));
            if (got.first_resync != want.first_resync)
                report("first_resync", 64'(got.first_resync), 64'(want.first_resync));
            if (got.multi_second != want.multi_second)
                report("multi_second", 64'(got.multi_second), 64'(want.multi_second));
            if (got.resync_total != want.resync_total)
                report("resync_total", 64'(got.resync_total), 64'(want.resync_total));
            if (got.multi_second_total != want.multi_second_total)
                report("multi_second_total", 64'(got.multi_second_total),
                       64'(want.multi_second_total));
        endtask
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [TIME_W-1:0]        edge_time;
    logic [WORD_W-1:0]        rtc_seconds;
    logic [TIME_W-1:0]        now_time;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WIDE_W-1:0] drift;
    logic signed [STEP_W-1:0] slew_step;
    logic [WORD_W-1:0]        slew_ticks;
    logic [WORD_W-1:0]        tick_length;
    logic                     first_resync;
    logic                     multi_second;
    logic [WORD_W-1:0]        resync_total;
    logic [WORD_W-1:0]        multi_second_total;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [WORD_W-1:0]        cfg_data;

    drift_scoreboard sb;
    // quiet turns off idling on both sides for a stretch
    bit              quiet;
    int              items_sent;
    int              settings_used;

    clock_drift_discipline #(
        .UNITS_PER_SECOND (UNITS_PER_SECOND_DEF)
    ) DUT (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .edge_time          (edge_time),
        .rtc_seconds        (rtc_seconds),
        .now_time           (now_time),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .drift              (drift),
        .slew_step          (slew_step),
        .slew_ticks         (slew_ticks),
        .tick_length        (tick_length),
        .first_resync       (first_resync),
        .multi_second       (multi_second),
        .resync_total       (resync_total),
        .multi_second_total (multi_second_total),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_gap();
        int roll;

        roll = $urandom_range(0, 99);
        if (quiet || roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    // result side: random stall bursts, checks on every accepted result
    initial
    begin
        int stall_left;

        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = pick_gap();
                if (stall_left != 0 && $urandom_range(0, 3) == 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                begin
                    stall_left = 0;
                    out_stall <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        resync_result_t got;

        if (rst_n && out_valid && !out_stall)
        begin
            got.drift              = drift;
            got.slew_step          = slew_step;
            got.slew_ticks         = slew_ticks;
            got.tick_length        = tick_length;
            got.first_resync       = first_resync;
            got.multi_second       = multi_second;
            got.resync_total       = resync_total;
            got.multi_second_total = multi_second_total;
            sb.check_result(got);
        end
    end

    // present one resync item, hold it until the block takes it
    task send_resync(logic [TIME_W-1:0] e, logic [31:0] r, logic [TIME_W-1:0] n);
        int gap;

        gap = pick_gap();
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        edge_time   <= e;
        rtc_seconds <= r;
        now_time    <= n;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_resync(e, r, n);
        items_sent++;
    endtask

    // drop the input, wait for every expected result, then let the block settle
    task wait_until_drained(int pause);
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (pause) @(posedge clk);
    endtask

    task write_setting(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.apply_setting(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // registers only change with the block idle
    task load_settings(logic [31:0] boot, logic [31:0] nominal);
        wait_until_drained(8);
        write_setting(REG_BOOT_SECONDS, boot);
        write_setting(REG_NOMINAL_TICK, nominal);
        settings_used++;
    endtask

    // mostly plausible resync streams: rtc steps forward, edge lands near the
    // matching second with a drift whose sign tends to repeat, so the tick
    // nudge path gets exercised; the rest is raw noise across all bits
    task run_random_phase(int count, logic [31:0] boot, logic [31:0] nominal, bit pause_mid);
        int          i;
        int          bits;
        logic [31:0] rtc_cur;
        logic [63:0] secs;
        logic [63:0] off;
        logic [63:0] e64;
        logic [63:0] n64;
        logic        behind;

        load_settings(boot, nominal);
        rtc_cur = boot + $urandom_range(0, 1000);
        behind  = 1'b0;
        for (i = 0; i < count; i++)
        begin
            // with pause_mid set, the sender holds off halfway until every result is back
            if (pause_mid && i == count / 2)
                wait_until_drained(0);
            if ($urandom_range(0, 99) < 15)
            begin
                e64 = {$urandom, $urandom};
                n64 = {$urandom, $urandom};
                send_resync(e64[TIME_W-1:0], $urandom, n64[TIME_W-1:0]);
            end
            else
            begin
                rtc_cur = rtc_cur + (($urandom_range(0, 9) == 0) ? $urandom_range(2, 120) : 1);
                secs    = {32'd0, rtc_cur} - {32'd0, boot};
                bits    = $urandom_range(0, 44);
                off     = (bits == 0) ? 64'd0 : ({$urandom, $urandom} >> (64 - bits));
                if ($urandom_range(0, 3) == 0)
                    behind = ~behind;
                e64 = secs * UNITS + (behind ? 64'd0 - off : off);
                if ($urandom_range(0, 49) == 0)
                    n64 = e64 - $urandom_range(1, 1000000);
                else
                    n64 = e64 + $urandom_range(0, 50000);
                send_resync(e64[TIME_W-1:0], rtc_cur, n64[TIME_W-1:0]);
            end
        end
    endtask

    // hard stop in case the block hangs
    initial
    begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        sb            = new();
        quiet         = 1'b0;
        items_sent    = 0;
        settings_used = 1;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        edge_time     = '0;
        rtc_seconds   = '0;
        now_time      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_BOOT_SECONDS;
        cfg_data      = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: boot 0, nominal 4000000
        // first event, zero drift
        send_resync('0, 32'd0, '0);
        // zero drift again, both signs count as not ahead so the nudge runs
        send_resync(62'd5_000_000_000, 32'd5, 62'd5_000_000_000);
        // small positive drift after zero: no sign match
        send_resync(62'd6_000_003_000, 32'd6, 62'd6_000_000_000);
        // positive again: tick shrinks
        send_resync(62'd7_009_000_000, 32'd7, 62'd7_000_000_000);
        // negative drift
        send_resync(62'd7_995_000_000, 32'd8, 62'd8_000_000_000);
        // negative again beyond one second: tick grows, multi-second
        send_resync(62'd7_000_000_000, 32'd9, 62'd9_000_000_000);
        // exactly one second ahead is not multi-second
        send_resync(62'd11_000_000_000, 32'd10, 62'd10_000_000_000);
        // largest edge: tick count saturates
        send_resync(TIME_MAX, 32'd0, TIME_MAX);
        // largest rtc with time going backwards
        send_resync('0, WORD_MAX, '0);
        // both at their largest: drift comes out positive, far beyond one second
        send_resync(TIME_MAX, WORD_MAX, TIME_MAX);
        send_resync('0, 32'd0, 62'd100);

        // largest boot and tick: rtc below boot gives a huge positive drift
        load_settings(WORD_MAX, WORD_MAX);
        send_resync('0, 32'd0, '0);
        // largest positive step
        send_resync(62'd1000, WORD_MAX, 62'd1000);
        send_resync('0, WORD_MAX, 62'd2000);

        // largest tick with negative drift: most negative step, tick wraps upward
        load_settings(32'd0, WORD_MAX);
        send_resync('0, 32'd1, 62'd1_000_000_000);
        send_resync('0, 32'd2, 62'd9_589_934_592);

        // tiny tick driven to zero by the nudge, then zero tick skips it
        load_settings(32'd100, 32'd12);
        send_resync('0, 32'd100, '0);
        send_resync(62'd16, 32'd100, 62'd12);
        send_resync(62'd16, 32'd100, 62'd24);
        send_resync(62'd50, 32'd100, 62'd36);

        // smallest tick: nudged below ten so the step drops to zero, then wraps
        load_settings(32'd100, 32'd10);
        send_resync('0, 32'd100, 62'd100);
        send_resync(62'd4, 32'd100, 62'd110);
        send_resync(62'd4, 32'd100, 62'd120);
        send_resync(62'd20, 32'd100, 62'd130);

        run_random_phase(ITEMS_PER_PHASE, $urandom, NOMINAL_RESET, 1'b0);
        run_random_phase(ITEMS_PER_PHASE, 32'd0, 32'd10, 1'b0);
        run_random_phase(ITEMS_PER_PHASE, WORD_MAX, WORD_MAX, 1'b1);
        run_random_phase(ITEMS_PER_PHASE, $urandom, $urandom_range(10, 200), 1'b0);
        run_random_phase(ITEMS_PER_PHASE, $urandom, $urandom_range(10, WORD_MAX), 1'b0);
        quiet = 1'b1;
        run_random_phase(ITEMS_PER_PHASE, $urandom, NOMINAL_RESET, 1'b0);
        quiet = 1'b0;

        wait_until_drained(DRAIN_WAIT);

        $display("ran %0d resync items over %0d register settings, directed corners first",
                 items_sent, settings_used);
        $display("compared %0d results field by field, %0d of them with multi-second drift",
                 sb.checked, sb.multi_seen);
        if (sb.mismatches == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
